[rtl/tccw_pkg.sv]
`timescale 1ns / 1ps
// shared constants, codes and types of the text console cell writer
package tccw_pkg;

   localparam int SCREEN_COLUMNS = 80;
   localparam int SCREEN_ROWS    = 25;
   localparam int CELL_COUNT     = SCREEN_COLUMNS * SCREEN_ROWS;
   localparam int CELL_IDX_W     = $clog2(CELL_COUNT);

   // fixed field widths
   localparam int CMD_W   = 2;
   localparam int GLYPH_W = 8;
   localparam int ADDR_W  = 11;
   localparam int COL_W   = 7;
   localparam int ROW_W   = 5;
   localparam int CELL_W  = 16;
   localparam int ATTR_W  = 8;

   localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;
   localparam logic [CMD_W-1:0] CMD_NONE  = 2'd3;

   localparam logic [GLYPH_W-1:0] CODE_NEWLINE   = 8'h0A;
   localparam logic [GLYPH_W-1:0] CODE_BACKSPACE = 8'h08;
   localparam logic [GLYPH_W-1:0] CODE_SPACE     = 8'h20;
   localparam logic [ATTR_W-1:0]  RESET_ATTRIBUTE = 8'h0F;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_CLEAR
   } state_type;

endpackage

[rtl/tccw_if.sv]
`timescale 1ns / 1ps
// valid/ready channel interfaces of the text console cell writer

interface tccw_req_if;
   logic                          valid;
   logic                          ready;
   logic [tccw_pkg::CMD_W-1:0]    cmd;
   logic [tccw_pkg::GLYPH_W-1:0]  glyph_code;
   logic [tccw_pkg::ADDR_W-1:0]   cell_address;

   modport source (output valid, cmd, glyph_code, cell_address, input ready);
   modport sink   (input valid, cmd, glyph_code, cell_address, output ready);
endinterface

interface tccw_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [tccw_pkg::COL_W-1:0]    cursor_col;
   logic [tccw_pkg::ROW_W-1:0]    cursor_row;
   logic [tccw_pkg::CELL_W-1:0]   cell_data;
   logic                          was_cleared;

   modport source (output valid, cursor_col, cursor_row, cell_data, was_cleared,
                   input ready);
   modport sink   (input valid, cursor_col, cursor_row, cell_data, was_cleared,
                   output ready);
endinterface

interface tccw_csr_if;
   logic                          valid;
   logic                          ready;
   logic [tccw_pkg::ATTR_W-1:0]   data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

[rtl/text_console_cell_writer.sv]
`timescale 1ns / 1ps
// text console cell writer: screen memory, cursor and clearing sweep
//
// channels
//   req_ch : commands in (put character, read one cell, clear screen)
//   rsp_ch : one result per command: cursor after the command, the read cell
//            (zero for other commands) and a flag when the screen was blanked
//   csr_ch : write of the text attribute byte, always ready
// sequence
//   a put or an unused command has its result registered at the accepting
//   edge; a read passes through ST_READ, where the data from the registered
//   read port of the screen memory goes into the result register
//   a clear, or a put that runs off the last row, returns its result at once
//   and then sweeps the screen memory one cell per cycle, all CELL_COUNT cells
//   (2000 at 80 x 25), during which no command is taken
// reset
//   cursor homes, attribute returns to 0x0F and the same sweep of all CELL_COUNT
//   cells blanks the screen before the first command is taken
// stall
//   a result waits in the output register; one further command is taken
//   only as that result is being transferred
module text_console_cell_writer (
   input  logic          clock,
   input  logic          reset,
   tccw_req_if.sink      req_ch,
   tccw_rsp_if.source    rsp_ch,
   tccw_csr_if.sink      csr_ch
);
   import tccw_pkg::*;

   // screen memory, no reset: the sweep fills it
   logic [CELL_W-1:0]     screen_mem [CELL_COUNT];
   logic                  mem_we;
   logic [CELL_IDX_W-1:0] mem_waddr;
   logic [CELL_W-1:0]     mem_wdata;
   logic                  mem_re;
   logic [CELL_W-1:0]     rd_data_ff;

   // control state
   state_type             state_ff, state_in;
   logic [COL_W-1:0]      col_ff, col_in;
   logic [ROW_W-1:0]      row_ff, row_in;
   logic [ATTR_W-1:0]     attr_ff;
   logic [CELL_W-1:0]     blank_ff, blank_in;
   logic [CELL_IDX_W-1:0] sweep_ff, sweep_in;
   logic                  rd_hit_ff, rd_hit_in;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [COL_W-1:0]      rsp_col_ff, rsp_col_in;
   logic [ROW_W-1:0]      rsp_row_ff, rsp_row_in;
   logic [CELL_W-1:0]     rsp_data_ff, rsp_data_in;
   logic                  rsp_clr_ff, rsp_clr_in;

   logic                  accept;
   logic                  rsp_free;
   logic                  rd_in_range;

   // put character datapath
   logic [COL_W-1:0]      wr_col;
   logic [COL_W-1:0]      put_col;
   logic [ROW_W-1:0]      put_row;
   logic                  put_we;
   logic [GLYPH_W-1:0]    put_glyph;
   logic                  put_wrap;
   logic                  put_over;
   logic [CELL_IDX_W-1:0] cursor_addr;

   assign csr_ch.ready = 1'b1;

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.cursor_col  = rsp_col_ff;
   assign rsp_ch.cursor_row  = rsp_row_ff;
   assign rsp_ch.cell_data   = rsp_data_ff;
   assign rsp_ch.was_cleared = rsp_clr_ff;

   // output slot is free now or is emptied at this edge
   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE) && rsp_free;
   assign accept       = req_ch.valid && req_ch.ready;

   assign rd_in_range = (int'(req_ch.cell_address) < CELL_COUNT);

   // cursor arithmetic for a put
   always_comb begin
      wr_col    = col_ff;
      put_col   = col_ff;
      put_row   = row_ff;
      put_we    = 1'b0;
      put_glyph = req_ch.glyph_code;
      if (req_ch.glyph_code == CODE_NEWLINE) begin
         put_col = '0;
         put_row = row_ff + ROW_W'(1);
      end else if (req_ch.glyph_code == CODE_BACKSPACE) begin
         // only steps back above column zero
         if (col_ff != '0) begin
            wr_col    = col_ff - COL_W'(1);
            put_col   = wr_col;
            put_we    = 1'b1;
            put_glyph = CODE_SPACE;
         end
      end else begin
         put_we  = 1'b1;
         put_col = col_ff + COL_W'(1);
      end
      put_wrap = (int'(put_col) >= SCREEN_COLUMNS);
      if (put_wrap) begin
         put_col = '0;
         put_row = put_row + ROW_W'(1);
      end
      put_over = (int'(put_row) >= SCREEN_ROWS);
   end

   // constant multiply for the linear cell index, cut to CELL_IDX_W bits
   assign cursor_addr = CELL_IDX_W'(int'(row_ff) * SCREEN_COLUMNS + int'(wr_col));

   // next state, memory port control and result register
   always_comb begin
      state_in     = state_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      blank_in     = blank_ff;
      sweep_in     = sweep_ff;
      rd_hit_in    = rd_hit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_col_in   = rsp_col_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_clr_in   = rsp_clr_ff;
      mem_we       = 1'b0;
      mem_waddr    = cursor_addr;
      mem_wdata    = {attr_ff, put_glyph};
      mem_re       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_data_in = '0;
               rsp_clr_in  = 1'b0;
               unique case (req_ch.cmd)
                  CMD_PUT: begin
                     mem_we = put_we;
                     if (put_over) begin
                        // ran off the last row: blank everything, home
                        col_in     = '0;
                        row_in     = '0;
                        blank_in   = {attr_ff, CODE_SPACE};
                        sweep_in   = '0;
                        state_in   = ST_CLEAR;
                        rsp_clr_in = 1'b1;
                     end else begin
                        col_in = put_col;
                        row_in = put_row;
                     end
                     rsp_valid_in = 1'b1;
                     rsp_col_in   = put_over ? '0 : put_col;
                     rsp_row_in   = put_over ? '0 : put_row;
                  end
                  CMD_READ: begin
                     // result follows once the memory data is back
                     mem_re    = 1'b1;
                     rd_hit_in = rd_in_range;
                     state_in  = ST_READ;
                  end
                  CMD_CLEAR: begin
                     col_in       = '0;
                     row_in       = '0;
                     blank_in     = {attr_ff, CODE_SPACE};
                     sweep_in     = '0;
                     state_in     = ST_CLEAR;
                     rsp_valid_in = 1'b1;
                     rsp_col_in   = '0;
                     rsp_row_in   = '0;
                     rsp_clr_in   = 1'b1;
                  end
                  CMD_NONE: begin
                     rsp_valid_in = 1'b1;
                     rsp_col_in   = col_ff;
                     rsp_row_in   = row_ff;
                  end
               endcase
            end
         end
         ST_READ: begin
            // output slot was emptied at the accepting edge
            rsp_valid_in = 1'b1;
            rsp_col_in   = col_ff;
            rsp_row_in   = row_ff;
            rsp_data_in  = rd_hit_ff ? rd_data_ff : '0;
            rsp_clr_in   = 1'b0;
            state_in     = ST_IDLE;
         end
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = sweep_ff;
            mem_wdata = blank_ff;
            sweep_in  = sweep_ff + CELL_IDX_W'(1);
            if (int'(sweep_ff) == CELL_COUNT - 1) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         col_ff       <= '0;
         row_ff       <= '0;
         attr_ff      <= RESET_ATTRIBUTE;
         blank_ff     <= {RESET_ATTRIBUTE, CODE_SPACE};
         sweep_ff     <= '0;
         rd_hit_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         blank_ff     <= blank_in;
         sweep_ff     <= sweep_in;
         rd_hit_ff    <= rd_hit_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_ch.valid && csr_ch.ready) begin
            attr_ff <= csr_ch.data;
         end
      end
   end

   // result payload, no reset needed
   always_ff @(posedge clock) begin
      rsp_col_ff  <= rsp_col_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_data_ff <= rsp_data_in;
      rsp_clr_ff  <= rsp_clr_in;
   end

   // screen memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         screen_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= screen_mem[req_ch.cell_address[CELL_IDX_W-1:0]];
      end
   end

endmodule

[tb/tb_text_console_cell_writer.sv]
`timescale 1ns / 1ps
// testbench of the text console cell writer: predicting scoreboard, bursty sender, stalling receiver
module tb_text_console_cell_writer;
   import tccw_pkg::*;

   // longest sender gap between bursts, in cycles
   localparam int unsigned MAX_GAP       = 12;
   // quiet time after the last result: one full clearing sweep and some margin
   localparam int unsigned SWEEP_CYCLES  = CELL_COUNT + 16;
   // long receiver hold-off: start of the count that holds ready low while requests keep coming
   localparam int unsigned HOLD_CYCLES   = 400;
   localparam int unsigned HOLD_AFTER    = 500;
   // least number of random commands per attribute setting (unused ones not counted), six settings in all
   localparam int unsigned PHASE_ITEMS   = 210;
   // slowest correct run: every command a full sweep plus the longest gap and
   // stall, over about 1600 commands, then taken several times over
   localparam int unsigned CYCLE_LIMIT   = 20_000_000;

   // what one result carries
   typedef struct packed {
      logic [COL_W-1:0]  col;
      logic [ROW_W-1:0]  row;
      logic [CELL_W-1:0] cell_bits;
      logic              cleared;
   } console_status_type;

   // scoreboard: own copy of the screen, cursor and attribute, and the results
   // that accepted commands are still owed
   class console_scoreboard;
      logic [CELL_W-1:0]  screen [CELL_COUNT];
      int unsigned        col_pos;
      int unsigned        row_pos;
      logic [ATTR_W-1:0]  attribute;
      console_status_type owed_status [$];
      int unsigned        mismatches;

      function new();
         attribute  = RESET_ATTRIBUTE;
         mismatches = 0;
         blank_screen();
      endfunction

      function void blank_screen();
         for (int i = 0; i < CELL_COUNT; i++)
            screen[i] = {attribute, CODE_SPACE};
         col_pos = 0;
         row_pos = 0;
      endfunction

      function void set_attribute(logic [ATTR_W-1:0] value);
         attribute = value;
      endfunction

      // apply one accepted command and queue the result it must give
      function void note_command(logic [CMD_W-1:0] cmd, logic [GLYPH_W-1:0] glyph,
                                 logic [ADDR_W-1:0] addr);
         console_status_type s;
         s.cell_bits = '0;
         s.cleared   = 1'b0;
         case (cmd)
            CMD_PUT: begin
               if (glyph == CODE_NEWLINE) begin
                  col_pos = 0;
                  row_pos++;
               end else if (glyph == CODE_BACKSPACE) begin
                  if (col_pos > 0) begin
                     col_pos--;
                     screen[row_pos * SCREEN_COLUMNS + col_pos] = {attribute, CODE_SPACE};
                  end
               end else begin
                  screen[row_pos * SCREEN_COLUMNS + col_pos] = {attribute, glyph};
                  col_pos++;
               end
               if (col_pos >= SCREEN_COLUMNS) begin
                  col_pos = 0;
                  row_pos++;
               end
               if (row_pos >= SCREEN_ROWS) begin
                  blank_screen();
                  s.cleared = 1'b1;
               end
            end
            CMD_READ: begin
               if (addr < CELL_COUNT)
                  s.cell_bits = screen[addr];
            end
            CMD_CLEAR: begin
               blank_screen();
               s.cleared = 1'b1;
            end
            default: ;  // unused command changes nothing
         endcase
         s.col = col_pos[COL_W-1:0];
         s.row = row_pos[ROW_W-1:0];
         owed_status.push_back(s);
      endfunction

      function void compare_field(string what, logic [CELL_W-1:0] want,
                                  logic [CELL_W-1:0] got);
         if (got !== want) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
         end
      endfunction

      function void check_result(console_status_type got);
         console_status_type want;
         if (owed_status.size() == 0) begin
            mismatches++;
            $display("%0t: result with none expected, expected nothing, actual %h", $time, got);
            return;
         end
         want = owed_status.pop_front();
         compare_field("cursor_col", CELL_W'(want.col), CELL_W'(got.col));
         compare_field("cursor_row", CELL_W'(want.row), CELL_W'(got.row));
         compare_field("cell_data", want.cell_bits, got.cell_bits);
         compare_field("was_cleared", CELL_W'(want.cleared), CELL_W'(got.cleared));
      endfunction
   endclass

   logic clock;
   logic reset;

   tccw_req_if req_ch ();
   tccw_rsp_if rsp_ch ();
   tccw_csr_if csr_ch ();

   text_console_cell_writer dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   console_scoreboard screen_sb = new();

   int unsigned burst_left    = 0;   // transfers left in the current sender burst
   int unsigned commands_sent = 0;   // accepted commands that the block acts on
   int unsigned results_seen  = 0;
   int unsigned cycle_count   = 0;

   // clock, 2 ns period
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // cycle counter and run limit
   initial begin
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_text_console_cell_writer: FAIL");
            $finish;
         end
      end
   end

   // receiver: checks every result transfer and stalls on a pattern of its own,
   // with one long hold-off once traffic is under way
   initial begin
      int unsigned        run_left;
      int unsigned        stall_left;
      int unsigned        hold_left;
      bit                 hold_done;
      logic               next_ready;
      console_status_type got;
      run_left   = 0;
      stall_left = 0;
      hold_left  = 0;
      hold_done  = 1'b0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            got.col       = rsp_ch.cursor_col;
            got.row       = rsp_ch.cursor_row;
            got.cell_bits = rsp_ch.cell_data;
            got.cleared   = rsp_ch.was_cleared;
            screen_sb.check_result(got);
            results_seen++;
         end
         if (hold_left > 0) begin
            hold_left--;
            next_ready = 1'b0;
         end else if (!hold_done && results_seen >= HOLD_AFTER && req_ch.valid) begin
            // long hold-off: the output register fills and input stalls behind it
            hold_done  = 1'b1;
            hold_left  = HOLD_CYCLES;
            next_ready = 1'b0;
         end else if (run_left > 0) begin
            run_left--;
            next_ready = 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            next_ready = 1'b0;
         end else begin
            // new pattern: sometimes a long clean run, else short runs and stalls
            if ($urandom_range(0, 9) == 0) begin
               run_left   = $urandom_range(60, 150);
               stall_left = 0;
            end else begin
               run_left   = $urandom_range(0, 10);
               stall_left = $urandom_range(0, 6);
            end
            next_ready = 1'b1;
         end
         rsp_ch.ready <= next_ready;
      end
   end

   // one command transfer; the sender works in bursts with random gaps between
   task automatic send_command(input logic [CMD_W-1:0] cmd,
                               input logic [GLYPH_W-1:0] glyph,
                               input logic [ADDR_W-1:0] addr);
      if (burst_left == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, MAX_GAP)) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                   : $urandom_range(1, 12);
      end
      req_ch.valid        <= 1'b1;
      req_ch.cmd          <= cmd;
      req_ch.glyph_code   <= glyph;
      req_ch.cell_address <= addr;
      do @(posedge clock); while (!req_ch.ready);
      screen_sb.note_command(cmd, glyph, addr);
      if (cmd != CMD_NONE)
         commands_sent++;
      burst_left--;
   endtask

   // stop offering, let every owed result arrive, then let a sweep finish
   task automatic settle_block();
      req_ch.valid <= 1'b0;
      burst_left = 0;
      while (screen_sb.owed_status.size() != 0)
         @(posedge clock);
      repeat (SWEEP_CYCLES) @(posedge clock);
   endtask

   // attribute write, only while the block is idle
   task automatic write_attribute(input logic [ATTR_W-1:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      screen_sb.set_attribute(value);
   endtask

   // random commands, mostly well-formed text with edits, reads and line runs
   task automatic run_random_phase(input int unsigned count);
      int unsigned       start;
      int unsigned       kind;
      int unsigned       n;
      int                near;
      logic [GLYPH_W-1:0] glyph;
      logic [ADDR_W-1:0]  addr;
      start = commands_sent;
      while (commands_sent - start < count) begin
         kind = $urandom_range(0, 99);
         if (kind < 45) begin
            // a line of text, mostly printable, now and then any byte
            n = $urandom_range(1, 100);
            repeat (n) begin
               glyph = GLYPH_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                             : $urandom_range(8'h21, 8'h7E));
               send_command(CMD_PUT, glyph, ADDR_W'($urandom_range(0, 2047)));
            end
            if ($urandom_range(0, 1) == 1)
               send_command(CMD_PUT, CODE_NEWLINE, ADDR_W'($urandom_range(0, 2047)));
         end else if (kind < 60) begin
            // short edits: backspaces mixed with characters
            repeat ($urandom_range(1, 8)) begin
               glyph = ($urandom_range(0, 1) == 1) ? CODE_BACKSPACE
                                                   : GLYPH_W'($urandom_range(8'h20, 8'h7E));
               send_command(CMD_PUT, glyph, ADDR_W'($urandom_range(0, 2047)));
            end
         end else if (kind < 80) begin
            // read back near the cursor, anywhere on screen, or past its end
            repeat ($urandom_range(1, 6)) begin
               case ($urandom_range(0, 2))
                  0: begin
                     near = int'(screen_sb.row_pos * SCREEN_COLUMNS + screen_sb.col_pos)
                            - int'($urandom_range(0, 3));
                     addr = (near < 0) ? '0 : near[ADDR_W-1:0];
                  end
                  1:       addr = ADDR_W'($urandom_range(0, CELL_COUNT - 1));
                  default: addr = ADDR_W'($urandom_range(0, 2047));
               endcase
               send_command(CMD_READ, GLYPH_W'($urandom_range(0, 255)), addr);
            end
         end else if (kind < 90) begin
            // newline run, often enough to run off the last row
            repeat ($urandom_range(1, 30))
               send_command(CMD_PUT, CODE_NEWLINE, ADDR_W'($urandom_range(0, 2047)));
         end else if (kind < 94) begin
            send_command(CMD_CLEAR, GLYPH_W'($urandom_range(0, 255)),
                         ADDR_W'($urandom_range(0, 2047)));
         end else begin
            // noise: any command with any content
            repeat ($urandom_range(1, 4))
               send_command(CMD_W'($urandom_range(0, 3)), GLYPH_W'($urandom_range(0, 255)),
                            ADDR_W'($urandom_range(0, 2047)));
         end
      end
   endtask

   // main stimulus
   initial begin
      logic [ATTR_W-1:0] attr_setting [6];
      attr_setting[0] = 8'h00;
      attr_setting[1] = 8'hFF;
      attr_setting[2] = ATTR_W'($urandom_range(1, 254));
      attr_setting[3] = 8'h80;
      attr_setting[4] = ATTR_W'($urandom_range(0, 255));
      attr_setting[5] = ATTR_W'($urandom_range(0, 255));

      // every input known from the start
      reset               <= 1'b1;
      req_ch.valid        <= 1'b0;
      req_ch.cmd          <= CMD_PUT;
      req_ch.glyph_code   <= '0;
      req_ch.cell_address <= '0;
      csr_ch.valid        <= 1'b0;
      csr_ch.data         <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed part under the reset attribute; the sender simply waits out
      // the clearing sweep after reset
      send_command(CMD_READ, 8'h00, 11'd0);                    // blank cell after reset
      send_command(CMD_READ, 8'hFF, ADDR_W'(CELL_COUNT - 1));  // last cell on screen
      send_command(CMD_READ, 8'h00, ADDR_W'(CELL_COUNT));      // first address past the screen
      send_command(CMD_READ, 8'h00, 11'h7FF);                  // top of the address field
      send_command(CMD_PUT, 8'h41, 11'h000);
      send_command(CMD_PUT, 8'h00, 11'h7FF);
      send_command(CMD_PUT, 8'hFF, 11'h555);
      send_command(CMD_PUT, CODE_SPACE, 11'h2AA);
      send_command(CMD_PUT, CODE_BACKSPACE, 11'h000);  // step back and blank
      send_command(CMD_READ, 8'h00, 11'd2);
      send_command(CMD_READ, 8'h00, 11'd1);
      send_command(CMD_PUT, CODE_NEWLINE, 11'h000);
      send_command(CMD_PUT, CODE_BACKSPACE, 11'h000);  // at column zero: no change
      send_command(CMD_NONE, 8'hFF, 11'h7FF);          // unused command
      send_command(CMD_NONE, 8'h00, 11'h000);
      send_command(CMD_PUT, 8'h7E, 11'h000);
      send_command(CMD_READ, 8'h00, ADDR_W'(SCREEN_COLUMNS));
      send_command(CMD_CLEAR, 8'hA5, 11'h7FF);         // clear and home
      send_command(CMD_READ, 8'h00, 11'd0);
      send_command(CMD_READ, 8'h00, ADDR_W'(SCREEN_COLUMNS));
      send_command(CMD_PUT, 8'h80, 11'h000);
      send_command(CMD_READ, 8'h00, 11'd0);

      // random phases, each under its own attribute, the extremes first
      for (int p = 0; p < 6; p++) begin
         settle_block();
         write_attribute(attr_setting[p]);
         run_random_phase(PHASE_ITEMS);
      end

      // drain, then watch for stray results over one more sweep
      settle_block();
      if (screen_sb.mismatches == 0) begin
         $display("tb_text_console_cell_writer: PASS");
      end else begin
         $display("tb_text_console_cell_writer: FAIL");
      end
      $finish;
   end

endmodule

[text_console_cell_writer.f]
rtl/tccw_pkg.sv
rtl/tccw_if.sv
rtl/text_console_cell_writer.sv
tb/tb_text_console_cell_writer.sv
